// File: design/psr_pkg.sv
// shared types, constants and codes of the pwm setpoint ramp
package psr_pkg;

	localparam int LEVEL_W    = 16;
	localparam int PRESCALE_W = 11;
	localparam int PROD_W     = LEVEL_W + PRESCALE_W;
	localparam int CNT_W      = $clog2(PROD_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [LEVEL_W-1:0]    STANDBY_LEVEL  = LEVEL_W'(40000);
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(1024);
	localparam logic [LEVEL_W-1:0]    DIVISOR_RESET  = LEVEL_W'(28800);
	localparam logic [LEVEL_W-1:0]    STEP_MAX       = '1;
	localparam logic [CNT_W-1:0]      DIV_LAST_CNT   = CNT_W'(PROD_W - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PRESCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DIVISOR  = 1'b1;

	// opcodes
	localparam logic OP_TARGET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [LEVEL_W-1:0] target_level;
	} psr_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] pwm_level;
		logic               ramp_busy;
	} psr_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_MULT,
		ST_DIV_INIT,
		ST_DIV,
		ST_STEP,
		ST_TICK,
		ST_PUSH
	} psr_state_t;

	typedef struct packed {
		logic capture;
		logic calc_dist;
		logic calc_mult;
		logic div_start;
		logic div_step;
		logic load_step;
		logic do_tick;
		logic push;
	} psr_cmd_t;

	typedef struct packed {
		logic op_tick;
		logic div_last;
		logic out_free;
	} psr_stat_t;

endpackage

// File: design/pwm_setpoint_ramp_core.sv
// top level of the pwm setpoint ramp
// Slew-rate limited PWM setpoint ramp. A target transaction (opcode 0) stores a new goal and
// computes the step |goal - level| * tick_prescale / ramp_divisor, saturated to 16 bits; each
// tick transaction (opcode 1) moves the level one step toward the goal and snaps to it when the
// remaining distance is within one step. Every transaction returns exactly one result with the
// level and the busy flag after it. A target transaction runs the 27-step restoring divider
// that produces one quotient bit per cycle. Items are processed one at a time; the output
// register holds a finished result so a new transaction can be taken while the result waits.
// Configuration writes take effect at once; the user must make them only while the block is
// idle, and the block itself does not enforce this.
module pwm_setpoint_ramp_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  psr_pkg::psr_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output psr_pkg::psr_out_t              out_item
);
	import psr_pkg::*;

	psr_cmd_t  cmd;
	psr_stat_t stat;

	// sequencer
	psr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic and state
	psr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: design/psr_ctrl.sv
// controller state machine of the pwm setpoint ramp
module psr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  psr_pkg::psr_stat_t stat,
	output psr_pkg::psr_cmd_t  cmd
);
	import psr_pkg::*;

	psr_state_t state_q;
	psr_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				state_d = stat.op_tick ? ST_TICK : ST_MULT;
			end
			ST_MULT:     state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: state_d = ST_PUSH;
			ST_TICK: state_d = ST_PUSH;
			ST_PUSH: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DIST:     cmd.calc_dist = 1'b1;
			ST_MULT:     cmd.calc_mult = 1'b1;
			ST_DIV_INIT: cmd.div_start = 1'b1;
			ST_DIV:      cmd.div_step  = 1'b1;
			ST_STEP:     cmd.load_step = 1'b1;
			ST_TICK:     cmd.do_tick   = 1'b1;
			ST_PUSH:     cmd.push      = stat.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: design/psr_dpath.sv
// datapath of the pwm setpoint ramp: ramp state, multiplier, serial divider, output register
module psr_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [psr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  psr_pkg::psr_in_t                   in_item,
	output psr_pkg::psr_out_t                  out_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	input  psr_pkg::psr_cmd_t                  cmd,
	output psr_pkg::psr_stat_t                 stat
);
	import psr_pkg::*;

	logic [PRESCALE_W-1:0] prescale_q;
	logic [LEVEL_W-1:0]    divisor_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [LEVEL_W-1:0]    goal_q;
	logic [LEVEL_W-1:0]    step_q;
	logic                  ramping_q;
	logic                  op_q;
	logic [LEVEL_W-1:0]    dist_s1;
	logic [PROD_W-1:0]     prod_s2;
	logic [PROD_W-1:0]     quo_q;
	logic [LEVEL_W-1:0]    rem_q;
	logic [CNT_W-1:0]      cnt_q;
	psr_out_t              out_q;
	logic                  out_valid_q;

	logic [LEVEL_W:0]      rem_sh;
	logic [LEVEL_W:0]      rem_diff;
	logic                  q_bit;
	logic                  quo_ovf;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PRESCALE_RESET;
			divisor_q  <= DIVISOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_PRESCALE: prescale_q <= cfg_data[PRESCALE_W-1:0];
				REG_RAMP_DIVISOR:  divisor_q  <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// captured opcode
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_item.opcode;
		end
	end

	// distance and scaled distance
	always_ff @(posedge clk) begin
		if (cmd.calc_dist) begin
			dist_s1 <= (goal_q > level_q) ? (goal_q - level_q) : (level_q - goal_q);
		end
		if (cmd.calc_mult) begin
			prod_s2 <= PROD_W'(dist_s1) * PROD_W'(prescale_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign q_bit    = ~rem_diff[LEVEL_W];

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= prod_s2;
			rem_q <= '0;
			cnt_q <= DIV_LAST_CNT;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[LEVEL_W-1:0] : rem_sh[LEVEL_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quo_ovf = |quo_q[PROD_W-1:LEVEL_W];

	// ramp state: new step on a target, one move per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= STANDBY_LEVEL;
			goal_q    <= STANDBY_LEVEL;
			step_q    <= '0;
			ramping_q <= 1'b0;
		end else begin
			if (cmd.capture && in_item.opcode == OP_TARGET) begin
				goal_q <= in_item.target_level;
			end
			if (cmd.load_step) begin
				if (divisor_q == '0 || quo_ovf) begin
					step_q <= STEP_MAX;
				end else begin
					step_q <= quo_q[LEVEL_W-1:0];
				end
				ramping_q <= 1'b1;
			end
			if (cmd.do_tick && ramping_q) begin
				if (step_q == '0 || dist_s1 <= step_q) begin
					level_q   <= goal_q;
					step_q    <= '0;
					ramping_q <= 1'b0;
				end else if (goal_q > level_q) begin
					level_q <= level_q + step_q;
				end else begin
					level_q <= level_q - step_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.pwm_level <= level_q;
			out_q.ramp_busy <= ramping_q;
		end
	end

	assign out_item      = out_q;
	assign out_valid     = out_valid_q;
	assign stat.op_tick  = (op_q == OP_TICK);
	assign stat.div_last = (cnt_q == '0);
	assign stat.out_free = ~out_valid_q | out_ready;

	// a zero divisor always saturates the step
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_step && divisor_q == '0 |=> step_q == STEP_MAX)
		else $error("zero divisor did not saturate the step");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over a waiting transaction");

	// the ramp only ends with the level on the goal
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ramping_q) |-> (level_q == goal_q && step_q == '0))
		else $error("ramp stopped away from the goal");

	// the step is only taken once the divider has run all its steps
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_step |-> $past(cmd.div_step) && $past(cnt_q) == '0)
		else $error("step loaded before the division finished");

endmodule
